// File: hw/rtl/radio_rx_fifo_port_defines.svh
// assertion macros for the receive fifo port
`ifndef RADIO_RX_FIFO_PORT_DEFINES_SVH
`define RADIO_RX_FIFO_PORT_DEFINES_SVH

`ifndef SYNTHESIS
`define RRFP_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define RRFP_ASSERT_NEXT(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`else
`define RRFP_ASSERT(lbl, clk, rst, prop, msg)
`define RRFP_ASSERT_NEXT(lbl, clk, rst, pre, post, msg)
`endif

`endif

// File: hw/rtl/rrfp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rrfp_pkg;

   localparam int unsigned WORD_W   = 16;
   localparam int unsigned OP_W     = 3;
   localparam int unsigned LEVEL_W  = 14;
   localparam int unsigned RC_W     = 15;

   // request opcodes
   localparam logic [OP_W-1:0] OP_BUS_READ  = 3'd0;
   localparam logic [OP_W-1:0] OP_BUS_WRITE = 3'd1;
   localparam logic [OP_W-1:0] OP_RX_WORD   = 3'd2;
   localparam logic [OP_W-1:0] OP_DMA_POP   = 3'd3;
   localparam logic [OP_W-1:0] OP_FLUSH     = 3'd4;

   // bus ports
   localparam logic [1:0] PORT_TX_HOLD = 2'd0;
   localparam logic [1:0] PORT_RX_DATA = 2'd1;
   localparam logic [1:0] PORT_TX_CTL  = 2'd2;
   localparam logic [1:0] PORT_RX_CTL  = 2'd3;

   // receive control register
   localparam logic [RC_W-1:0]   RC_KEEP      = 15'h7F83;
   localparam logic [RC_W-1:0]   RC_RESET_VAL = 15'h3C82;
   localparam logic [WORD_W-1:0] TC_RESET_VAL = 16'h059E;
   localparam int unsigned RC_RRST_BIT = 1;
   localparam int unsigned RC_THR_LSB  = 7;
   localparam int unsigned RC_RINT_BIT = 11;
   localparam int unsigned RC_RDMA_BIT = 13;

   // status bits
   localparam int unsigned ST_READY_BIT = 2;
   localparam int unsigned ST_OVR_BIT   = 3;
   localparam int unsigned ST_THR_BIT   = 4;
   localparam int unsigned ST_EMPTY_BIT = 5;
   localparam int unsigned ST_FULL_BIT  = 6;

   typedef struct packed {
      logic clear;
      logic push;
      logic pop;
   } fifo_ctl_type;

endpackage

`default_nettype wire

// File: hw/rtl/rrfp_channels.sv
`timescale 1ns / 1ps
`default_nettype none

interface rrfp_req_if import rrfp_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [OP_W-1:0]   opcode;
   logic [15:0]       port_addr;
   logic [WORD_W-1:0] data;
   logic              last_of_burst;
   logic              window_open;

   modport source (output valid, opcode, port_addr, data, last_of_burst, window_open,
                   input ready);
   modport sink   (input valid, opcode, port_addr, data, last_of_burst, window_open,
                   output ready);
endinterface

interface rrfp_rsp_if import rrfp_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [WORD_W-1:0]  read_data;
   logic               port_hit;
   logic               pop_valid;
   logic               rx_interrupt;
   logic               dma_request;
   logic               overrun_now;
   logic               dropped_no_window;
   logic [LEVEL_W-1:0] level;

   modport source (output valid, read_data, port_hit, pop_valid, rx_interrupt, dma_request,
                   overrun_now, dropped_no_window, level, input ready);
   modport sink   (input valid, read_data, port_hit, pop_valid, rx_interrupt, dma_request,
                   overrun_now, dropped_no_window, level, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/rrfp_stage_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module rrfp_stage_ram import rrfp_pkg::*; #(
   parameter int unsigned DEPTH  = 8192,
   parameter int unsigned ADDR_W = 13
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WORD_W-1:0] wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WORD_W-1:0] rd_data
);

   logic [WORD_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

// File: hw/rtl/rrfp_rx_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module rrfp_rx_fifo import rrfp_pkg::*; #(
   parameter  int unsigned DEPTH = 4,
   localparam int unsigned CNT_W = $clog2(DEPTH + 1)
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire fifo_ctl_type      ctl,
   input  wire logic [WORD_W-1:0] push_word,
   output logic      [CNT_W-1:0]  count,
   output logic      [WORD_W-1:0] head_word
);

   logic [WORD_W-1:0] words_ff [DEPTH];
   logic [CNT_W-1:0]  count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (ctl.clear) begin
         count_ff <= '0;
      end else if (ctl.pop) begin
         count_ff <= count_ff - CNT_W'(1);
      end else if (ctl.push) begin
         count_ff <= count_ff + CNT_W'(1);
      end
   end

   // pop shifts towards the head, the top slot becomes stale
   always_ff @(posedge clock) begin
      for (int i = 0; i < DEPTH; i++) begin
         if (ctl.pop) begin
            words_ff[i] <= words_ff[(i + 1) % DEPTH];
         end else if (ctl.push && count_ff == CNT_W'(i)) begin
            words_ff[i] <= push_word;
         end
      end
   end

   assign count     = count_ff;
   assign head_word = words_ff[0];

endmodule

`default_nettype wire

// File: hw/rtl/radio_rx_fifo_port.sv
// receive fifo port of a radio serial interface
// req_bus carries one request: bus read or write of ports 0-3, a received word,
// a dma pop or a flush; rsp_bus returns exactly one result per request, in order
// csr_wr_en / csr_wr_data write the ready-bit-unused control bit; the user must
// write it only when idle, the block does not enforce it
// received words go into a staging ring memory (single write port, single read
// port, registered read) that pours into a small fifo of registers
// a request is taken only when the sequencer is idle; the result is held in an
// output register, so the next request is taken while the last result waits
// a plain access passes execute and finish; a request that refills the fifo adds
// refill passes, and every word moved from the ring takes one ring read and one
// fifo push; a receive data read makes two refill passes around its pop step and
// moves up to FIFO_DEPTH+1 words
// reset clears counts, pointers and registers at once; ring and fifo contents are
// left as they are and the counts keep stale words unseen; no clearing pass
// a stalled result (rsp_bus.ready low) holds the sequencer in its finish step
`timescale 1ns / 1ps
`default_nettype none
`include "radio_rx_fifo_port_defines.svh"

module radio_rx_fifo_port import rrfp_pkg::*; #(
   parameter int unsigned FIFO_DEPTH  = 4,
   parameter int unsigned STAGE_DEPTH = 8192
) (
   input  wire logic clock,
   input  wire logic reset,
   rrfp_req_if.sink   req_bus,
   rrfp_rsp_if.source rsp_bus,
   input  wire logic csr_wr_en,
   input  wire logic csr_wr_data
);

   localparam int unsigned CNT_W  = $clog2(FIFO_DEPTH + 1);
   localparam int unsigned ADDR_W = $clog2(STAGE_DEPTH);
   localparam int unsigned SCNT_W = $clog2(STAGE_DEPTH + 1);
   localparam int unsigned SUM_W  = (SCNT_W + 1 > LEVEL_W) ? SCNT_W + 1 : LEVEL_W;

   // sequencer states
   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_EXEC   = 3'd1;
   localparam logic [2:0] S_RF_RD  = 3'd2;
   localparam logic [2:0] S_RF_WR  = 3'd3;
   localparam logic [2:0] S_POP    = 3'd4;
   localparam logic [2:0] S_FINISH = 3'd5;

   logic [2:0] state_ff, state_in;

   // captured request
   logic [OP_W-1:0]   op_ff,   op_in;
   logic [15:0]       pa_ff,   pa_in;
   logic [WORD_W-1:0] d_ff,    d_in;
   logic              last_ff, last_in;
   logic              win_ff,  win_in;
   logic              phase_ff, phase_in;   // set once the final refill is under way

   // result being built
   logic [WORD_W-1:0] res_rd_ff,   res_rd_in;
   logic              res_hit_ff,  res_hit_in;
   logic              res_popv_ff, res_popv_in;
   logic              res_irq_ff,  res_irq_in;
   logic              res_dreq_ff, res_dreq_in;
   logic              res_ovr_ff,  res_ovr_in;
   logic              res_drop_ff, res_drop_in;

   // output register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0]  rsp_rd_ff,    rsp_rd_in;
   logic               rsp_hit_ff,   rsp_hit_in;
   logic               rsp_popv_ff,  rsp_popv_in;
   logic               rsp_irq_ff,   rsp_irq_in;
   logic               rsp_dreq_ff,  rsp_dreq_in;
   logic               rsp_ovr_ff,   rsp_ovr_in;
   logic               rsp_drop_ff,  rsp_drop_in;
   logic [LEVEL_W-1:0] rsp_level_ff, rsp_level_in;

   // block registers
   logic [WORD_W-1:0] hold_ff,   hold_in;    // receive hold
   logic [RC_W-1:0]   rc_ff,     rc_in;      // receive control, kept bits only
   logic [WORD_W-1:0] tc_ff,     tc_in;      // transmit control
   logic [WORD_W-1:0] th_ff,     th_in;      // transmit hold
   logic              sticky_ff, sticky_in;  // overrun flag
   logic              rbu_ff,    rbu_in;     // ready bit unused

   // staging ring pointers
   logic [ADDR_W-1:0] head_ff,   head_in;
   logic [SCNT_W-1:0] scount_ff, scount_in;

   // ring port
   logic              ram_we, ram_re;
   logic [ADDR_W-1:0] ram_waddr;
   logic [WORD_W-1:0] ram_rdata;

   // fifo
   fifo_ctl_type      fifo_ctl;
   logic [CNT_W-1:0]  fifo_count;
   logic [WORD_W-1:0] fifo_head;

   // helpers
   logic              req_take;
   logic              rsp_free;
   logic              port_ok;
   logic              stage_full;
   logic              fifo_has_room;
   logic [ADDR_W-1:0] head_inc;
   logic [ADDR_W:0]   tail_sum;
   logic [ADDR_W-1:0] tail_addr;
   logic [2:0]        thr_raw, thr;
   logic [WORD_W-1:0] status_word;
   logic [SUM_W-1:0]  level_sum;

   rrfp_stage_ram #(
      .DEPTH  (STAGE_DEPTH),
      .ADDR_W (ADDR_W)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (d_ff),
      .rd_en   (ram_re),
      .rd_addr (head_ff),
      .rd_data (ram_rdata)
   );

   rrfp_rx_fifo #(
      .DEPTH (FIFO_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .ctl       (fifo_ctl),
      .push_word (ram_rdata),
      .count     (fifo_count),
      .head_word (fifo_head)
   );

   assign req_bus.ready = (state_ff == S_IDLE);
   assign req_take      = req_bus.valid && (state_ff == S_IDLE);
   assign rsp_free      = !rsp_valid_ff || rsp_bus.ready;

   assign port_ok       = (pa_ff[15:2] == '0);
   assign stage_full    = (scount_ff == SCNT_W'(STAGE_DEPTH));
   assign fifo_has_room = (fifo_count < CNT_W'(FIFO_DEPTH));
   assign head_inc      = (head_ff == ADDR_W'(STAGE_DEPTH - 1)) ? '0 : head_ff + ADDR_W'(1);

   // tail position, head plus count wrapped once
   assign tail_sum  = {1'b0, head_ff} + (ADDR_W + 1)'(scount_ff);
   assign tail_addr = (tail_sum >= (ADDR_W + 1)'(STAGE_DEPTH))
                    ? ADDR_W'(tail_sum - (ADDR_W + 1)'(STAGE_DEPTH))
                    : tail_sum[ADDR_W-1:0];

   // threshold clamped to 1..FIFO_DEPTH
   assign thr_raw = rc_ff[RC_THR_LSB +: 3];
   always_comb begin
      thr = thr_raw;
      if (thr_raw == 3'd0) begin
         thr = 3'd1;
      end else if (thr_raw > 3'(FIFO_DEPTH)) begin
         thr = 3'(FIFO_DEPTH);
      end
   end

   always_comb begin
      status_word = {1'b0, rc_ff & RC_KEEP};
      status_word[ST_EMPTY_BIT] = (fifo_count == '0);
      status_word[ST_THR_BIT]   = (3'(fifo_count) >= thr);
      status_word[ST_FULL_BIT]  = (fifo_count >= CNT_W'(FIFO_DEPTH));
      status_word[ST_OVR_BIT]   = sticky_ff;
      status_word[ST_READY_BIT] = !rbu_ff && (fifo_count != '0);
   end

   assign level_sum = SUM_W'(fifo_count) + SUM_W'(scount_ff);

   // sequencer
   always_comb begin
      state_in    = state_ff;
      op_in       = op_ff;
      pa_in       = pa_ff;
      d_in        = d_ff;
      last_in     = last_ff;
      win_in      = win_ff;
      phase_in    = phase_ff;
      res_rd_in   = res_rd_ff;
      res_hit_in  = res_hit_ff;
      res_popv_in = res_popv_ff;
      res_irq_in  = res_irq_ff;
      res_dreq_in = res_dreq_ff;
      res_ovr_in  = res_ovr_ff;
      res_drop_in = res_drop_ff;
      hold_in     = hold_ff;
      rc_in       = rc_ff;
      tc_in       = tc_ff;
      th_in       = th_ff;
      sticky_in   = sticky_ff;
      head_in     = head_ff;
      scount_in   = scount_ff;
      ram_we      = 1'b0;
      ram_re      = 1'b0;
      ram_waddr   = tail_addr;
      fifo_ctl    = '0;

      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_rd_in    = rsp_rd_ff;
      rsp_hit_in   = rsp_hit_ff;
      rsp_popv_in  = rsp_popv_ff;
      rsp_irq_in   = rsp_irq_ff;
      rsp_dreq_in  = rsp_dreq_ff;
      rsp_ovr_in   = rsp_ovr_ff;
      rsp_drop_in  = rsp_drop_ff;
      rsp_level_in = rsp_level_ff;

      rbu_in = csr_wr_en ? csr_wr_data : rbu_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               op_in       = req_bus.opcode;
               pa_in       = req_bus.port_addr;
               d_in        = req_bus.data;
               last_in     = req_bus.last_of_burst;
               win_in      = req_bus.window_open;
               phase_in    = 1'b0;
               res_rd_in   = '0;
               res_hit_in  = 1'b0;
               res_popv_in = 1'b0;
               res_irq_in  = 1'b0;
               res_dreq_in = 1'b0;
               res_ovr_in  = 1'b0;
               res_drop_in = 1'b0;
               state_in    = S_EXEC;
            end
         end

         S_EXEC: begin
            state_in = S_FINISH;
            unique case (op_ff)
               OP_BUS_READ: begin
                  if (port_ok) begin
                     res_hit_in = 1'b1;
                     unique case (pa_ff[1:0])
                        PORT_TX_HOLD: res_rd_in = th_ff;
                        PORT_RX_DATA: begin
                           // refill, pop into the hold register, refill again
                           res_rd_in = hold_ff;
                           state_in  = S_RF_RD;
                        end
                        PORT_TX_CTL:  res_rd_in = tc_ff;
                        PORT_RX_CTL:  res_rd_in = status_word;
                        default:      res_rd_in = '0;
                     endcase
                  end
               end
               OP_BUS_WRITE: begin
                  if (port_ok) begin
                     res_hit_in = 1'b1;
                     unique case (pa_ff[1:0])
                        PORT_TX_HOLD: th_in = d_ff;
                        PORT_TX_CTL:  tc_in = d_ff;
                        PORT_RX_CTL: begin
                           rc_in = d_ff[RC_W-1:0] & RC_KEEP;
                           // receiver reset: falling edge of the reset bit
                           if (rc_ff[RC_RRST_BIT] && !d_ff[RC_RRST_BIT]) begin
                              sticky_in      = 1'b0;
                              fifo_ctl.clear = 1'b1;
                              head_in        = '0;
                              scount_in      = '0;
                           end
                        end
                        default: begin
                           // receive data write is taken and ignored
                        end
                     endcase
                  end
               end
               OP_RX_WORD: begin
                  if (!win_ff) begin
                     res_drop_in = 1'b1;
                  end else begin
                     ram_we = 1'b1;
                     if (stage_full) begin
                        // oldest staged word is overwritten by the new one
                        ram_waddr  = head_ff;
                        head_in    = head_inc;
                        sticky_in  = 1'b1;
                        res_ovr_in = 1'b1;
                     end else begin
                        scount_in = scount_ff + SCNT_W'(1);
                     end
                     res_irq_in  = last_ff && !rc_ff[RC_RINT_BIT];
                     res_dreq_in = last_ff && !rc_ff[RC_RDMA_BIT];
                     phase_in    = 1'b1;
                     state_in    = S_RF_RD;
                  end
               end
               OP_DMA_POP: begin
                  // only an empty fifo is refilled before the pop
                  state_in = (fifo_count == '0) ? S_RF_RD : S_POP;
               end
               OP_FLUSH: begin
                  fifo_ctl.clear = 1'b1;
                  head_in        = '0;
                  scount_in      = '0;
               end
               default: begin
                  // unknown opcode: zero result, no change
               end
            endcase
         end

         S_RF_RD: begin
            if (fifo_has_room && scount_ff != '0) begin
               ram_re    = 1'b1;
               head_in   = head_inc;
               scount_in = scount_ff - SCNT_W'(1);
               state_in  = S_RF_WR;
            end else if (phase_ff || fifo_count == '0) begin
               state_in = S_FINISH;
            end else begin
               state_in = S_POP;
            end
         end

         S_RF_WR: begin
            fifo_ctl.push = 1'b1;
            state_in      = S_RF_RD;
         end

         S_POP: begin
            fifo_ctl.pop = 1'b1;
            res_rd_in    = fifo_head;
            if (op_ff == OP_BUS_READ) begin
               hold_in  = fifo_head;
               phase_in = 1'b1;
               state_in = S_RF_RD;
            end else begin
               res_popv_in = 1'b1;
               if (fifo_count == CNT_W'(1) && scount_ff == '0) begin
                  sticky_in = 1'b0;
               end
               state_in = S_FINISH;
            end
         end

         S_FINISH: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_rd_in    = res_rd_ff;
               rsp_hit_in   = res_hit_ff;
               rsp_popv_in  = res_popv_ff;
               rsp_irq_in   = res_irq_ff;
               rsp_dreq_in  = res_dreq_ff;
               rsp_ovr_in   = res_ovr_ff;
               rsp_drop_in  = res_drop_ff;
               rsp_level_in = level_sum[LEVEL_W-1:0];
               state_in     = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         hold_ff      <= '0;
         rc_ff        <= RC_RESET_VAL;
         tc_ff        <= TC_RESET_VAL;
         th_ff        <= '0;
         sticky_ff    <= 1'b0;
         rbu_ff       <= 1'b0;
         head_ff      <= '0;
         scount_ff    <= '0;
         phase_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         hold_ff      <= hold_in;
         rc_ff        <= rc_in;
         tc_ff        <= tc_in;
         th_ff        <= th_in;
         sticky_ff    <= sticky_in;
         rbu_ff       <= rbu_in;
         head_ff      <= head_in;
         scount_ff    <= scount_in;
         phase_ff     <= phase_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      pa_ff        <= pa_in;
      d_ff         <= d_in;
      last_ff      <= last_in;
      win_ff       <= win_in;
      res_rd_ff    <= res_rd_in;
      res_hit_ff   <= res_hit_in;
      res_popv_ff  <= res_popv_in;
      res_irq_ff   <= res_irq_in;
      res_dreq_ff  <= res_dreq_in;
      res_ovr_ff   <= res_ovr_in;
      res_drop_ff  <= res_drop_in;
      rsp_rd_ff    <= rsp_rd_in;
      rsp_hit_ff   <= rsp_hit_in;
      rsp_popv_ff  <= rsp_popv_in;
      rsp_irq_ff   <= rsp_irq_in;
      rsp_dreq_ff  <= rsp_dreq_in;
      rsp_ovr_ff   <= rsp_ovr_in;
      rsp_drop_ff  <= rsp_drop_in;
      rsp_level_ff <= rsp_level_in;
   end

   assign rsp_bus.valid             = rsp_valid_ff;
   assign rsp_bus.read_data         = rsp_rd_ff;
   assign rsp_bus.port_hit          = rsp_hit_ff;
   assign rsp_bus.pop_valid         = rsp_popv_ff;
   assign rsp_bus.rx_interrupt      = rsp_irq_ff;
   assign rsp_bus.dma_request       = rsp_dreq_ff;
   assign rsp_bus.overrun_now       = rsp_ovr_ff;
   assign rsp_bus.dropped_no_window = rsp_drop_ff;
   assign rsp_bus.level             = rsp_level_ff;

   // checks
   `RRFP_ASSERT(a_fifo_bound, clock, reset, fifo_count <= CNT_W'(FIFO_DEPTH), "fifo count past depth")
   `RRFP_ASSERT(a_ring_bound, clock, reset, scount_ff <= SCNT_W'(STAGE_DEPTH), "ring count past depth")
   `RRFP_ASSERT(a_head_range, clock, reset, head_ff <= ADDR_W'(STAGE_DEPTH - 1), "ring head out of range")
   `RRFP_ASSERT_NEXT(a_refill_push, clock, reset, ram_re, state_ff == S_RF_WR && fifo_has_room, "ring read not followed by fifo push")

endmodule

`default_nettype wire
